// File: hw/rtl/ws2812_pixel_stream_driver_defines.svh
// ----------------------------------------------------------------------------
// ws2812 pixel stream driver defines
// assertion macros shared by wsd_ctrl and wsd_dp, clocked on clk_i, reset rst_ni
// ----------------------------------------------------------------------------
`ifndef WS2812_PIXEL_STREAM_DRIVER_DEFINES_SVH
`define WS2812_PIXEL_STREAM_DRIVER_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define WSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// types, constants and helper functions of the ws2812 pixel stream driver
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam int unsigned CH_W         = 8;
  localparam int unsigned PIX_W        = 24;
  localparam int unsigned BITS_PER_LED = 24;
  localparam int unsigned BIT_W        = 5;
  localparam int unsigned DUTY_W       = 10;
  localparam int unsigned CFG_W        = 10;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned NUM_W        = 2 * CH_W;
  localparam int unsigned DIV_STEPS    = 8;
  localparam int unsigned DIV_CNT_W    = 3;
  localparam int unsigned DVS_W        = CH_W + DIV_STEPS - 1;
  localparam int unsigned CHANNELS     = 3;

  // reciprocal of seven, exact for arguments up to 6 * 255
  localparam int unsigned RECIP7       = 2341;
  localparam int unsigned RECIP7_SHIFT = 14;
  localparam int unsigned MIX_W        = 11;
  localparam int unsigned PROD7_W      = 23;

  localparam logic [CFG_IDX_W-1:0] CFG_BRIGHTNESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ZERO  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_ONE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DUTY_RESET = 2'd3;

  localparam logic [CH_W-1:0]   BRIGHTNESS_RST = 8'd255;
  localparam logic [DUTY_W-1:0] DUTY_ZERO_RST  = 10'd34;
  localparam logic [DUTY_W-1:0] DUTY_ONE_RST   = 10'd67;
  localparam logic [DUTY_W-1:0] DUTY_RESET_RST = 10'd0;

  typedef enum logic [1:0] {
    FUNC_SET_ONE = 2'd0,
    FUNC_SET_ALL = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_TICK    = 2'd3
  } wsd_func_e;

  typedef struct packed {
    logic accept;
    logic mix;
    logic scale;
    logic step;
    logic px_write;
    logic fill_write;
    logic clear;
    logic tick;
  } wsd_cmd_t;

  function automatic logic [CH_W-1:0] div7(input logic [MIX_W-1:0] x);
    logic [PROD7_W-1:0] p;
    p = PROD7_W'(x) * PROD7_W'(RECIP7);
    return p[RECIP7_SHIFT +: CH_W];
  endfunction

  // rgbw mixing of one channel: floor(c*6/7) + floor(w/7)
  function automatic logic [CH_W-1:0] mix_chan(input logic [CH_W-1:0] c,
                                               input logic [CH_W-1:0] w);
    logic [MIX_W-1:0] c6;
    c6 = MIX_W'({c, 2'b00}) + MIX_W'({c, 1'b0});
    return div7(c6) + div7(MIX_W'(w));
  endfunction

endpackage

// File: hw/rtl/wsd_ram.sv
// ----------------------------------------------------------------------------
// wsd_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module wsd_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 60,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/wsd_ctrl.sv
// ----------------------------------------------------------------------------
// wsd_ctrl
// controller: sequences pixel writes, store clears and bit ticks
// ----------------------------------------------------------------------------
`include "ws2812_pixel_stream_driver_defines.svh"

module wsd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [1:0]        func_i,
  output logic              busy,
  output wsd_pkg::wsd_cmd_t cmd_o,
  output logic              done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX,
    ST_SCALE,
    ST_DIV,
    ST_WRITE,
    ST_CLEAR,
    ST_TICK
  } state_e;

  state_e                             state_q;
  logic                               busy_q;
  logic                               all_q;
  logic [wsd_pkg::DIV_CNT_W-1:0]      cnt_q;
  wsd_pkg::wsd_cmd_t                  cmd_q;
  logic                               done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      all_q   <= 1'b0;
      cnt_q   <= '0;
      cmd_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      cmd_q  <= '0;
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start && !busy_q) begin
            busy_q <= 1'b1;
            case (func_i) inside
              wsd_pkg::FUNC_SET_ONE, wsd_pkg::FUNC_SET_ALL: begin
                state_q   <= ST_MIX;
                all_q     <= (func_i == wsd_pkg::FUNC_SET_ALL);
                cmd_q.mix <= 1'b1;
              end
              wsd_pkg::FUNC_CLEAR: begin
                state_q     <= ST_CLEAR;
                cmd_q.clear <= 1'b1;
              end
              default: begin
                state_q    <= ST_TICK;
                cmd_q.tick <= 1'b1;
              end
            endcase
          end
        end
        ST_MIX: begin
          state_q     <= ST_SCALE;
          cmd_q.scale <= 1'b1;
        end
        ST_SCALE: begin
          state_q    <= ST_DIV;
          cnt_q      <= wsd_pkg::DIV_CNT_W'(wsd_pkg::DIV_STEPS - 1);
          cmd_q.step <= 1'b1;
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            state_q          <= ST_WRITE;
            cmd_q.px_write   <= !all_q;
            cmd_q.fill_write <= all_q;
          end else begin
            cnt_q      <= cnt_q - 1'b1;
            cmd_q.step <= 1'b1;
          end
        end
        ST_WRITE, ST_CLEAR: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
        ST_TICK: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    cmd_o        = cmd_q;
    cmd_o.accept = start && !busy_q;
  end

  assign busy   = busy_q;
  assign done_o = done_q;

  `WSD_ASSERT(a_tick_result, (start && !busy_q && func_i == wsd_pkg::FUNC_TICK) |-> ##2 done_q, "tick without result two cycles later")
  `WSD_ASSERT_NEXT(a_single_result, done_q, !done_q, "result strobe longer than one cycle")
  `WSD_ASSERT(a_result_idle, done_q |-> !busy_q, "result strobe while still busy")

endmodule

// File: hw/rtl/wsd_dp.sv
// ----------------------------------------------------------------------------
// wsd_dp
// datapath: colour mixing and scaling, pixel store, frame slot sequencing
// ----------------------------------------------------------------------------
`include "ws2812_pixel_stream_driver_defines.svh"

module wsd_dp #(
  parameter int unsigned LED_COUNT         = 60,
  parameter int unsigned LEAD_RESET_SLOTS  = 50,
  parameter int unsigned TRAIL_RESET_SLOTS = 50
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  wsd_pkg::wsd_cmd_t                 cmd_i,
  input  logic [7:0]                        led_index_i,
  input  logic [wsd_pkg::CH_W-1:0]          red_i,
  input  logic [wsd_pkg::CH_W-1:0]          green_i,
  input  logic [wsd_pkg::CH_W-1:0]          blue_i,
  input  logic [wsd_pkg::CH_W-1:0]          white_i,
  input  logic                              use_white_i,
  input  logic                              cfg_we_i,
  input  logic [wsd_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wsd_pkg::CFG_W-1:0]         cfg_data_i,
  output logic [wsd_pkg::DUTY_W-1:0]        duty_o,
  output logic                              frame_start_o
);

  localparam int unsigned ADDR_W      = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned DATA_SLOTS  = LED_COUNT * wsd_pkg::BITS_PER_LED;
  localparam int unsigned STOP_SLOT   = LEAD_RESET_SLOTS + DATA_SLOTS;
  localparam int unsigned FRAME_SLOTS = STOP_SLOT + 1 + TRAIL_RESET_SLOTS;
  localparam int unsigned SLOT_W      = $clog2(FRAME_SLOTS);
  localparam int unsigned IDX_CODES   = 256;

  localparam logic [SLOT_W-1:0]         LEAD_END   = SLOT_W'(LEAD_RESET_SLOTS);
  localparam logic [SLOT_W-1:0]         STOP_POS   = SLOT_W'(STOP_SLOT);
  localparam logic [SLOT_W-1:0]         LAST_SLOT  = SLOT_W'(FRAME_SLOTS - 1);
  localparam logic [ADDR_W-1:0]         LAST_LED   = ADDR_W'(LED_COUNT - 1);
  localparam logic [wsd_pkg::BIT_W-1:0] LAST_BIT   = wsd_pkg::BIT_W'(wsd_pkg::BITS_PER_LED - 1);

  // index reduction table
  logic [ADDR_W-1:0] mod_tbl [IDX_CODES];

  for (genvar g = 0; g < IDX_CODES; g++) begin : g_mod
    assign mod_tbl[g] = ADDR_W'(g % LED_COUNT);
  end

  // configuration registers
  logic [wsd_pkg::CH_W-1:0]   brightness_q;
  logic [wsd_pkg::DUTY_W-1:0] duty_zero_q;
  logic [wsd_pkg::DUTY_W-1:0] duty_one_q;
  logic [wsd_pkg::DUTY_W-1:0] duty_reset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brightness_q <= wsd_pkg::BRIGHTNESS_RST;
      duty_zero_q  <= wsd_pkg::DUTY_ZERO_RST;
      duty_one_q   <= wsd_pkg::DUTY_ONE_RST;
      duty_reset_q <= wsd_pkg::DUTY_RESET_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wsd_pkg::CFG_BRIGHTNESS: brightness_q <= cfg_data_i[wsd_pkg::CH_W-1:0];
        wsd_pkg::CFG_DUTY_ZERO:  duty_zero_q  <= cfg_data_i;
        wsd_pkg::CFG_DUTY_ONE:   duty_one_q   <= cfg_data_i;
        wsd_pkg::CFG_DUTY_RESET: duty_reset_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // colour path, channel 0 green, 1 red, 2 blue
  logic [ADDR_W-1:0]          idx_q;
  logic [wsd_pkg::CH_W-1:0]   chan_q  [wsd_pkg::CHANNELS];
  logic [wsd_pkg::CH_W-1:0]   white_q;
  logic                       use_white_q;
  logic [wsd_pkg::CH_W-1:0]   mixed_q [wsd_pkg::CHANNELS];
  logic [wsd_pkg::NUM_W-1:0]  rem_q   [wsd_pkg::CHANNELS];
  logic [wsd_pkg::CH_W-1:0]   quo_q   [wsd_pkg::CHANNELS];
  logic [wsd_pkg::DVS_W-1:0]  dvs_q;
  logic                       mzero_q;

  logic [wsd_pkg::CH_W-1:0]   max_gr;
  logic [wsd_pkg::CH_W-1:0]   max_c;
  logic                       ge      [wsd_pkg::CHANNELS];
  logic [wsd_pkg::NUM_W-1:0]  rem_sub [wsd_pkg::CHANNELS];
  logic [wsd_pkg::PIX_W-1:0]  colour;

  always_comb begin
    max_gr = (mixed_q[0] > mixed_q[1]) ? mixed_q[0] : mixed_q[1];
    max_c  = (mixed_q[2] > max_gr) ? mixed_q[2] : max_gr;
    for (int i = 0; i < wsd_pkg::CHANNELS; i++) begin
      ge[i]      = rem_q[i] >= wsd_pkg::NUM_W'(dvs_q);
      rem_sub[i] = rem_q[i] - wsd_pkg::NUM_W'(dvs_q);
    end
    colour = mzero_q ? '0 : {quo_q[0], quo_q[1], quo_q[2]};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q       <= mod_tbl[led_index_i];
      chan_q[0]   <= green_i;
      chan_q[1]   <= red_i;
      chan_q[2]   <= blue_i;
      white_q     <= white_i;
      use_white_q <= use_white_i;
    end
    if (cmd_i.mix) begin
      for (int i = 0; i < wsd_pkg::CHANNELS; i++) begin
        mixed_q[i] <= use_white_q ? wsd_pkg::mix_chan(chan_q[i], white_q) : chan_q[i];
      end
    end
    if (cmd_i.scale) begin
      for (int i = 0; i < wsd_pkg::CHANNELS; i++) begin
        rem_q[i] <= wsd_pkg::NUM_W'(mixed_q[i]) * wsd_pkg::NUM_W'(brightness_q);
        quo_q[i] <= '0;
      end
      dvs_q   <= {max_c, (wsd_pkg::DIV_STEPS - 1)'(0)};
      mzero_q <= (max_c == '0);
    end
    if (cmd_i.step) begin
      for (int i = 0; i < wsd_pkg::CHANNELS; i++) begin
        if (ge[i]) begin
          rem_q[i] <= rem_sub[i];
        end
        quo_q[i] <= {quo_q[i][wsd_pkg::CH_W-2:0], ge[i]};
      end
      dvs_q <= dvs_q >> 1;
    end
  end

  // pixel store: ram plus per-entry valid bits, invalid entries read as fill
  logic [LED_COUNT-1:0]       valid_q;
  logic [wsd_pkg::PIX_W-1:0]  fill_q;
  logic [ADDR_W-1:0]          led_q;
  logic [wsd_pkg::BIT_W-1:0]  bit_q;
  logic [SLOT_W-1:0]          slot_q;
  logic [wsd_pkg::PIX_W-1:0]  rdata;
  logic                       vld_rd_q;

  wsd_ram #(
    .WIDTH (wsd_pkg::PIX_W),
    .DEPTH (LED_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.px_write),
    .waddr_i (idx_q),
    .wdata_i (colour),
    .raddr_i (led_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      fill_q  <= '0;
    end else if (cmd_i.clear) begin
      valid_q <= '0;
      fill_q  <= '0;
    end else if (cmd_i.fill_write) begin
      valid_q <= '0;
      fill_q  <= colour;
    end else if (cmd_i.px_write) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // slot sequencing
  logic                       in_lead;
  logic                       in_data;
  logic                       in_stop;
  logic [wsd_pkg::PIX_W-1:0]  pixel;
  logic                       bit_v;
  logic [wsd_pkg::DUTY_W-1:0] duty_d;
  logic [wsd_pkg::DUTY_W-1:0] duty_q;
  logic                       fs_q;

  always_comb begin
    in_lead = slot_q < LEAD_END;
    in_stop = slot_q == STOP_POS;
    in_data = !in_lead && (slot_q < STOP_POS);
    pixel   = vld_rd_q ? rdata : fill_q;
    bit_v   = pixel[LAST_BIT - bit_q];
    if (in_data) begin
      duty_d = bit_v ? duty_one_q : duty_zero_q;
    end else if (in_stop) begin
      duty_d = duty_zero_q;
    end else begin
      duty_d = duty_reset_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      led_q  <= '0;
      bit_q  <= '0;
    end else if (cmd_i.tick) begin
      if (slot_q == LAST_SLOT) begin
        slot_q <= '0;
        led_q  <= '0;
        bit_q  <= '0;
      end else begin
        slot_q <= slot_q + 1'b1;
        if (in_data) begin
          if (bit_q == LAST_BIT) begin
            bit_q <= '0;
            led_q <= (led_q == LAST_LED) ? '0 : led_q + 1'b1;
          end else begin
            bit_q <= bit_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    vld_rd_q <= valid_q[led_q];
    if (cmd_i.tick) begin
      duty_q <= duty_d;
      fs_q   <= (slot_q == '0);
    end
  end

  assign duty_o        = duty_q;
  assign frame_start_o = fs_q;

  `WSD_ASSERT(a_position_range, (32'(led_q) < LED_COUNT) && (bit_q <= LAST_BIT), "led or bit position out of range")

endmodule

// File: hw/rtl/ws2812_pixel_stream_driver.sv
// ----------------------------------------------------------------------------
// ws2812_pixel_stream_driver
// colour store for a ws2812 led string with per-slot pwm duty output
// ----------------------------------------------------------------------------
// commands enter on start/func_i with led_index_i, colour and use_white_i
// fields, taken at an edge with start high and busy low. set-one and set-all
// mix and scale the colour, then write one entry or the whole store; clear
// zeroes the store; a tick returns the pwm duty of the current frame slot.
// only ticks produce a transaction: duty_o and frame_start_o are valid for the
// one cycle done_o is high, once the taken tick has passed the command register
// and then the result registers. the receiver cannot stall, and there is no
// back-pressure on the result side. set-one and set-all hold busy through mix,
// scale multiply, 8 steps of the restoring divider and write, so the divider
// loop, busy throughout, sets the pixel write rate. set-all and clear take effect
// at once through a fill colour and per-entry valid bits over the ram.
// configuration writes on cfg_we_i take effect at the next edge. after reset
// the store is all zero and the frame restarts at its first lead reset slot.
// ----------------------------------------------------------------------------
module ws2812_pixel_stream_driver #(
  parameter int unsigned LED_COUNT         = 60,
  parameter int unsigned LEAD_RESET_SLOTS  = 50,
  parameter int unsigned TRAIL_RESET_SLOTS = 50
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func_i,
  input  logic [7:0]                    led_index_i,
  input  logic [wsd_pkg::CH_W-1:0]      red_i,
  input  logic [wsd_pkg::CH_W-1:0]      green_i,
  input  logic [wsd_pkg::CH_W-1:0]      blue_i,
  input  logic [wsd_pkg::CH_W-1:0]      white_i,
  input  logic                          use_white_i,
  input  logic                          cfg_we_i,
  input  logic [wsd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wsd_pkg::CFG_W-1:0]     cfg_data_i,
  output logic [wsd_pkg::DUTY_W-1:0]    duty_o,
  output logic                          frame_start_o,
  output logic                          done_o
);

  wsd_pkg::wsd_cmd_t cmd;

  wsd_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .func_i (func_i),
    .busy   (busy),
    .cmd_o  (cmd),
    .done_o (done_o)
  );

  wsd_dp #(
    .LED_COUNT         (LED_COUNT),
    .LEAD_RESET_SLOTS  (LEAD_RESET_SLOTS),
    .TRAIL_RESET_SLOTS (TRAIL_RESET_SLOTS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .led_index_i   (led_index_i),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .white_i       (white_i),
    .use_white_i   (use_white_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .duty_o        (duty_o),
    .frame_start_o (frame_start_o)
  );

endmodule

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// checks the ws2812 pixel stream driver against a cycle-free model of its
// color store and frame position: pixel, fill and clear commands update the
// model, and each tick transaction is compared with the duty and frame start
// that the model predicts for the current slot
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  localparam int unsigned LED_COUNT   = 60;
  localparam int unsigned LEAD_SLOTS  = 50;
  localparam int unsigned TRAIL_SLOTS = 50;
  localparam int unsigned DATA_SLOTS  = LED_COUNT * wsd_pkg::BITS_PER_LED;
  localparam int unsigned FRAME_SLOTS = LEAD_SLOTS + DATA_SLOTS + 1 + TRAIL_SLOTS;
  localparam int unsigned SETTLE      = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    wsd_pkg::wsd_func_e func;
    logic [7:0]         idx;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         white;
    logic               mix;
  } pixel_cmd_t;

  typedef struct {
    logic [wsd_pkg::DUTY_W-1:0] duty;
    logic                       frame_start;
  } slot_result_t;

  logic                          clk_i;
  logic                          rst_ni = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [1:0]                    func_i = wsd_pkg::FUNC_TICK;
  logic [7:0]                    led_index_i = '0;
  logic [wsd_pkg::CH_W-1:0]      red_i = '0;
  logic [wsd_pkg::CH_W-1:0]      green_i = '0;
  logic [wsd_pkg::CH_W-1:0]      blue_i = '0;
  logic [wsd_pkg::CH_W-1:0]      white_i = '0;
  logic                          use_white_i = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [wsd_pkg::CFG_IDX_W-1:0] cfg_index_i = wsd_pkg::CFG_BRIGHTNESS;
  logic [wsd_pkg::CFG_W-1:0]     cfg_data_i = '0;
  logic [wsd_pkg::DUTY_W-1:0]    duty_o;
  logic                          frame_start_o;
  logic                          done_o;

  pixel_cmd_t   pending_cmds[$];
  slot_result_t expected_slots[$];
  logic         cmd_taken = 1'b0;
  int unsigned  gap_pct = 0;
  int unsigned  cycle_cnt = 0;
  int unsigned  err_cnt = 0;
  int unsigned  cmd_cnt = 0;
  int unsigned  slot_cnt = 0;
  int unsigned  frame_cnt = 0;
  int unsigned  cfg_cnt = 0;

  // model state
  logic [wsd_pkg::PIX_W-1:0]  px_store [LED_COUNT];
  int unsigned                slot_pos;
  logic [wsd_pkg::CH_W-1:0]   brightness;
  logic [wsd_pkg::DUTY_W-1:0] duty_zero;
  logic [wsd_pkg::DUTY_W-1:0] duty_one;
  logic [wsd_pkg::DUTY_W-1:0] duty_reset;

  ws2812_pixel_stream_driver #(
    .LED_COUNT        (LED_COUNT),
    .LEAD_RESET_SLOTS (LEAD_SLOTS),
    .TRAIL_RESET_SLOTS(TRAIL_SLOTS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .func_i       (func_i),
    .led_index_i  (led_index_i),
    .red_i        (red_i),
    .green_i      (green_i),
    .blue_i       (blue_i),
    .white_i      (white_i),
    .use_white_i  (use_white_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .duty_o       (duty_o),
    .frame_start_o(frame_start_o),
    .done_o       (done_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // rgbw mix, then scale so the largest channel lands on the gain
  function automatic logic [wsd_pkg::PIX_W-1:0] scaled_colour(
      input pixel_cmd_t c, input logic [wsd_pkg::CH_W-1:0] gain);
    int unsigned cr, cg, cb, wq, top;
    cr = c.red;
    cg = c.green;
    cb = c.blue;
    if (c.mix) begin
      wq = c.white / 7;
      cr = cr * 6 / 7 + wq;
      cg = cg * 6 / 7 + wq;
      cb = cb * 6 / 7 + wq;
    end
    top = cr;
    if (cg > top) top = cg;
    if (cb > top) top = cb;
    if (top == 0) return '0;
    return {8'(cg * gain / top), 8'(cr * gain / top), 8'(cb * gain / top)};
  endfunction

  function automatic slot_result_t frame_slot();
    slot_result_t r;
    int unsigned  k;
    if (slot_pos >= FRAME_SLOTS) slot_pos = 0;
    r.frame_start = (slot_pos == 0);
    if (slot_pos < LEAD_SLOTS) begin
      r.duty = duty_reset;
    end else if (slot_pos - LEAD_SLOTS < DATA_SLOTS) begin
      k = slot_pos - LEAD_SLOTS;
      r.duty = px_store[k / wsd_pkg::BITS_PER_LED]
                       [wsd_pkg::PIX_W - 1 - (k % wsd_pkg::BITS_PER_LED)] ? duty_one
                                                                           : duty_zero;
    end else if (slot_pos - LEAD_SLOTS == DATA_SLOTS) begin
      r.duty = duty_zero;
    end else begin
      r.duty = duty_reset;
    end
    slot_pos = slot_pos + 1;
    if (slot_pos >= FRAME_SLOTS) slot_pos = 0;
    return r;
  endfunction

  // driver
  always @(negedge clk_i) begin : driver
    pixel_cmd_t nxt;
    if (rst_ni && (!start || cmd_taken)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = pending_cmds.pop_front();
        start       <= 1'b1;
        func_i      <= nxt.func;
        led_index_i <= nxt.idx;
        red_i       <= nxt.red;
        green_i     <= nxt.green;
        blue_i      <= nxt.blue;
        white_i     <= nxt.white;
        use_white_i <= nxt.mix;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and scoreboard
  always @(posedge clk_i) begin : monitor
    pixel_cmd_t   got;
    slot_result_t want;
    cmd_taken <= start && !busy;
    if (rst_ni && start && !busy) begin
      got = '{func: wsd_pkg::wsd_func_e'(func_i), idx: led_index_i, red: red_i,
              green: green_i, blue: blue_i, white: white_i, mix: use_white_i};
      cmd_cnt++;
      case (got.func)
        wsd_pkg::FUNC_SET_ONE:
          px_store[got.idx % LED_COUNT] = scaled_colour(got, brightness);
        wsd_pkg::FUNC_SET_ALL:
          foreach (px_store[i]) px_store[i] = scaled_colour(got, brightness);
        wsd_pkg::FUNC_CLEAR: foreach (px_store[i]) px_store[i] = '0;
        default: expected_slots.push_back(frame_slot());
      endcase
    end
    if (rst_ni && done_o) begin
      if (expected_slots.size() == 0) begin
        $error("transaction with none expected: duty %0d frame_start %0d",
               duty_o, frame_start_o);
        err_cnt++;
      end else begin
        want = expected_slots.pop_front();
        slot_cnt++;
        if (frame_start_o === 1'b1) frame_cnt++;
        if (duty_o !== want.duty) begin
          $error("duty: expected %0d, got %0d", want.duty, duty_o);
          err_cnt++;
        end
        if (frame_start_o !== want.frame_start) begin
          $error("frame_start: expected %0d, got %0d", want.frame_start, frame_start_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("status: fail");
      $finish;
    end
  end

  task automatic push_cmd(input wsd_pkg::wsd_func_e f, input logic [7:0] idx,
                          input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                          input logic [7:0] w, input logic mix);
    pending_cmds.push_back('{func: f, idx: idx, red: r, green: g, blue: b, white: w,
                             mix: mix});
  endtask

  function automatic logic [7:0] rand_chan();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_random(input int unsigned n);
    int unsigned        pick;
    wsd_pkg::wsd_func_e f;
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 60) f = wsd_pkg::FUNC_TICK;
      else if (pick < 88) f = wsd_pkg::FUNC_SET_ONE;
      else if (pick < 96) f = wsd_pkg::FUNC_SET_ALL;
      else f = wsd_pkg::FUNC_CLEAR;
      push_cmd(f, 8'($urandom_range(255)), rand_chan(), rand_chan(), rand_chan(), rand_chan(),
               1'($urandom_range(1)));
    end
  endtask

  // wait for the queue, the driver and the scoreboard to empty, then settle
  task automatic drain();
    while (pending_cmds.size() != 0 || start || expected_slots.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [wsd_pkg::CH_W-1:0] bright,
                           input logic [wsd_pkg::DUTY_W-1:0] dz,
                           input logic [wsd_pkg::DUTY_W-1:0] d1,
                           input logic [wsd_pkg::DUTY_W-1:0] dr);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= wsd_pkg::CFG_BRIGHTNESS;
    cfg_data_i <= wsd_pkg::CFG_W'(bright);
    brightness = bright;
    @(negedge clk_i);
    cfg_index_i <= wsd_pkg::CFG_DUTY_ZERO;
    cfg_data_i <= dz;
    duty_zero = dz;
    @(negedge clk_i);
    cfg_index_i <= wsd_pkg::CFG_DUTY_ONE;
    cfg_data_i <= d1;
    duty_one = d1;
    @(negedge clk_i);
    cfg_index_i <= wsd_pkg::CFG_DUTY_RESET;
    cfg_data_i <= dr;
    duty_reset = dr;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_cnt++;
  endtask

  task automatic run_phase(input int unsigned gap, input int unsigned n);
    @(posedge clk_i);
    gap_pct = gap;
    push_random(n);
    drain();
  endtask

  initial begin
    foreach (px_store[i]) px_store[i] = '0;
    slot_pos   = 0;
    brightness = wsd_pkg::BRIGHTNESS_RST;
    duty_zero  = wsd_pkg::DUTY_ZERO_RST;
    duty_one   = wsd_pkg::DUTY_ONE_RST;
    duty_reset = wsd_pkg::DUTY_RESET_RST;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(posedge clk_i);

    // directed: index wrap, zero color, mixing, fill, clear mid-frame
    write_cfg(8'd255, 10'd34, 10'd67, 10'd5);
    @(posedge clk_i);
    gap_pct = 17;
    push_cmd(wsd_pkg::FUNC_SET_ONE, 8'd0, 8'hff, 8'h00, 8'h80, 8'h00, 1'b0);
    push_cmd(wsd_pkg::FUNC_SET_ONE, 8'd1, 8'h00, 8'hff, 8'h00, 8'hff, 1'b1);
    push_cmd(wsd_pkg::FUNC_SET_ONE, 8'd255, 8'd1, 8'd2, 8'd3, 8'h00, 1'b0);
    push_cmd(wsd_pkg::FUNC_SET_ONE, 8'(LED_COUNT), 8'h80, 8'h40, 8'h01, 8'h7f, 1'b1);
    push_cmd(wsd_pkg::FUNC_SET_ONE, 8'd3, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_cmd(wsd_pkg::FUNC_SET_ONE, 8'(LED_COUNT - 1), 8'h00, 8'h00, 8'h00, 8'hff, 1'b1);
    repeat (6) push_cmd(wsd_pkg::FUNC_TICK, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    push_cmd(wsd_pkg::FUNC_SET_ALL, 8'h00, 8'hff, 8'hff, 8'hff, 8'hff, 1'b1);
    repeat (2) push_cmd(wsd_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    push_cmd(wsd_pkg::FUNC_CLEAR, 8'h55, 8'haa, 8'h55, 8'haa, 8'h55, 1'b0);
    repeat (3) push_cmd(wsd_pkg::FUNC_TICK, 8'haa, 8'h55, 8'haa, 8'h55, 8'haa, 1'b1);
    push_cmd(wsd_pkg::FUNC_SET_ONE, 8'd2, 8'h80, 8'h80, 8'h80, 8'h00, 1'b0);
    repeat (2) push_cmd(wsd_pkg::FUNC_TICK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
    drain();

    write_cfg(8'd1, 10'd0, 10'd1023, 10'd512);
    run_phase(17, 130);
    write_cfg(8'd0, 10'd1023, 10'd0, 10'd1023);
    run_phase(72, 50);
    write_cfg(8'($urandom_range(255)), 10'($urandom_range(1023)), 10'($urandom_range(1023)),
              10'($urandom_range(1023)));
    run_phase(72, 90);
    write_cfg(8'd255, 10'($urandom_range(1023)), 10'($urandom_range(1023)),
              10'($urandom_range(1023)));
    run_phase(0, 130);

    $display("ran %0d commands under %0d register settings", cmd_cnt, cfg_cnt);
    $display("checked %0d tick transactions across %0d frame starts", slot_cnt, frame_cnt);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+hw/rtl
hw/rtl/wsd_pkg.sv
hw/rtl/wsd_ram.sv
hw/rtl/wsd_ctrl.sv
hw/rtl/wsd_dp.sv
hw/rtl/ws2812_pixel_stream_driver.sv
dv/tb.sv
